// ===== hw/rtl/dacf_pkg.sv =====
// ----------------------------------------------------------------------------
// dacf_pkg: shared types for the dual converter average current filter
// Word formats on the three channels, the queued command word, the
// configuration register set and the register index codes.
// ----------------------------------------------------------------------------
package dacf_pkg;

  // Width of one converter sample on the ports.
  localparam int SAMPLE_W = 12;
  // Width of a configuration data word.
  localparam int CFG_DATA_W = 24;
  // Width of a configuration register index.
  localparam int CFG_IDX_W = 3;
  // Depth of the command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  // One input word.
  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample_left;
    logic [SAMPLE_W-1:0] sample_right;
  } dacf_in_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0]  filtered_current;
    logic [SAMPLE_W-1:0] mean_left;
    logic [SAMPLE_W-1:0] mean_right;
    logic                saturated;
  } dacf_out_t;

  // Kind of a queued command.
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_t;

  // Classified command word held in the queue.
  typedef struct packed {
    kind_t               kind;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } dacf_cmd_t;

  // Configuration register set.
  typedef struct packed {
    logic [23:0]        volts_per_lsb;
    logic signed [23:0] offset_left;
    logic signed [23:0] offset_right;
    logic signed [23:0] current_gain;
    logic signed [17:0] coeff_input;
    logic signed [17:0] coeff_feedback;
  } dacf_cfg_t;

  // Configuration register index codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOLTS_PER_LSB  = 3'd0,
    REG_OFFSET_LEFT    = 3'd1,
    REG_OFFSET_RIGHT   = 3'd2,
    REG_CURRENT_GAIN   = 3'd3,
    REG_COEFF_INPUT    = 3'd4,
    REG_COEFF_FEEDBACK = 3'd5
  } cfg_reg_t;

endpackage

// ===== hw/rtl/dacf_front.sv =====
// ----------------------------------------------------------------------------
// dacf_front: input side and command queue
// Accepts input words, tags them as sample pair or query, masks the samples
// to the converter resolution and holds them in a short queue for the back.
// ----------------------------------------------------------------------------
module dacf_front
  import dacf_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  dacf_in_t  in_data,
  output logic      in_full,
  output logic      cmd_valid_o,
  output dacf_cmd_t cmd_o,
  input  logic      cmd_ready_i
);

  // Bits of a sample that are kept.
  localparam int KEEP = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SMASK = SAMPLE_W'((64'd1 << KEEP) - 64'd1);

  dacf_cmd_t         q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;
  dacf_cmd_t         cmd_new;

  // Classify the incoming word.
  always_comb begin
    cmd_new.kind  = in_data.req_type ? KIND_QUERY : KIND_SAMPLE;
    cmd_new.left  = in_data.sample_left & SMASK;
    cmd_new.right = in_data.sample_right & SMASK;
  end

  assign in_full     = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign cmd_valid_o = (cnt_r != '0);
  assign cmd_o       = q_mem_r[rd_ptr_r];
  assign do_push     = in_push & ~in_full;
  assign do_pop      = cmd_valid_o & cmd_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

// ===== hw/rtl/dacf_back.sv =====
// ----------------------------------------------------------------------------
// dacf_back: block averager and current filter sequencer
// Accumulates sample pairs, divides the closed block by a reciprocal multiply,
// and runs queries through multiply, sum, gain and saturate steps.
// ----------------------------------------------------------------------------
module dacf_back
  import dacf_pkg::*;
#(
  parameter int SAMPLES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dacf_cfg_t cfg_i,
  input  logic      cmd_valid_i,
  input  dacf_cmd_t cmd_i,
  output logic      cmd_ready_o,
  output logic      res_valid_o,
  output dacf_out_t res_o,
  input  logic      res_ready_i
);

  localparam int SUM_W = 24;
  localparam int RW    = $clog2(SAMPLES + 1);
  localparam logic [RW-1:0] SAMPLES_C = RW'(SAMPLES);
  // Reciprocal of the block length, exact for every SUM_W-bit sum:
  // floor(x / SAMPLES) = (x * RECIP) >> RECIP_SH.
  localparam int     RECIP_SH = SUM_W + $clog2(SAMPLES);
  localparam longint RECIP_L  = ((longint'(1) << RECIP_SH) + longint'(SAMPLES) - 1)
                              / longint'(SAMPLES);
  localparam logic [SUM_W:0] RECIP = (SUM_W + 1)'(RECIP_L);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_SUM  = 6'b001000,
    ST_GAIN = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  // Saturate a value to signed 32 bits; the top bit returned is the clip flag.
  function automatic logic [32:0] sat32(input logic signed [38:0] v);
    logic hi, lo;
    hi = !v[38] && (v[37:31] != 7'h00);
    lo = v[38] && (v[37:31] != 7'h7F);
    if (hi) begin
      sat32 = {1'b1, 32'h7FFF_FFFF};
    end else if (lo) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b0, v[31:0]};
    end
  endfunction

  state_t                 state_r, state_nxt;
  logic [RW-1:0]          blk_cnt_r, blk_cnt_nxt;
  logic [SUM_W-1:0]       sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic [SAMPLE_W-1:0]    mean_l_r, mean_l_nxt, mean_r_r, mean_r_nxt;
  logic signed [31:0]     prev_raw_r, prev_raw_nxt;
  logic signed [31:0]     prev_filt_r, prev_filt_nxt;

  // Divider working registers.
  logic [SUM_W-1:0]       dvd_l_r, dvd_l_nxt, dvd_r_r, dvd_r_nxt;
  logic [2*SUM_W:0]       quo_l_full, quo_r_full;

  // Query datapath registers.
  logic [35:0]            vl_r, vr_r;
  logic signed [49:0]     pc1_r, pc2_r;
  logic signed [30:0]     diff_r;
  logic signed [50:0]     acc_r;
  logic signed [54:0]     prod_r;
  logic signed [31:0]     y_r;
  logic                   ysat_r;

  logic [SUM_W:0]         add_l, add_r;
  logic signed [30:0]     diff_nxt;
  logic [32:0]            y_sat, raw_sat;

  assign cmd_ready_o = (state_r == ST_IDLE);
  assign res_valid_o = (state_r == ST_EMIT);

  // Saturating block sums.
  assign add_l = {1'b0, sum_l_r} + (SUM_W + 1)'(cmd_i.left);
  assign add_r = {1'b0, sum_r_r} + (SUM_W + 1)'(cmd_i.right);

  // Block means by reciprocal multiplication of the registered sums.
  assign quo_l_full = dvd_l_r * RECIP;
  assign quo_r_full = dvd_r_r * RECIP;

  // Voltage difference with offsets.
  assign diff_nxt = ($signed({3'b000, vl_r[35:8]}) - cfg_i.offset_left)
                  - ($signed({3'b000, vr_r[35:8]}) - cfg_i.offset_right);

  assign y_sat   = sat32({{4{acc_r[50]}}, acc_r[50:16]});
  assign raw_sat = sat32(prod_r[54:16]);

  // Result word.
  always_comb begin
    res_o.filtered_current = y_r;
    res_o.mean_left        = mean_l_r;
    res_o.mean_right       = mean_r_r;
    res_o.saturated        = ysat_r | raw_sat[32];
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    blk_cnt_nxt   = blk_cnt_r;
    sum_l_nxt     = sum_l_r;
    sum_r_nxt     = sum_r_r;
    mean_l_nxt    = mean_l_r;
    mean_r_nxt    = mean_r_r;
    prev_raw_nxt  = prev_raw_r;
    prev_filt_nxt = prev_filt_r;
    dvd_l_nxt     = dvd_l_r;
    dvd_r_nxt     = dvd_r_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.kind == KIND_QUERY) begin
            state_nxt = ST_MUL;
          end else if (blk_cnt_r < SAMPLES_C) begin
            sum_l_nxt   = add_l[SUM_W] ? {SUM_W{1'b1}} : add_l[SUM_W-1:0];
            sum_r_nxt   = add_r[SUM_W] ? {SUM_W{1'b1}} : add_r[SUM_W-1:0];
            blk_cnt_nxt = blk_cnt_r + 1'b1;
          end else begin
            // Block closes: this pair is dropped and the sums go to the divider.
            blk_cnt_nxt = '0;
            dvd_l_nxt   = sum_l_r;
            dvd_r_nxt   = sum_r_r;
            sum_l_nxt   = '0;
            sum_r_nxt   = '0;
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        mean_l_nxt = quo_l_full[RECIP_SH +: SAMPLE_W];
        mean_r_nxt = quo_r_full[RECIP_SH +: SAMPLE_W];
        state_nxt  = ST_IDLE;
      end
      ST_MUL: begin
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          prev_raw_nxt  = raw_sat[31:0];
          prev_filt_nxt = y_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blk_cnt_r   <= '0;
      sum_l_r     <= '0;
      sum_r_r     <= '0;
      mean_l_r    <= '0;
      mean_r_r    <= '0;
      prev_raw_r  <= '0;
      prev_filt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      sum_l_r     <= sum_l_nxt;
      sum_r_r     <= sum_r_nxt;
      mean_l_r    <= mean_l_nxt;
      mean_r_r    <= mean_r_nxt;
      prev_raw_r  <= prev_raw_nxt;
      prev_filt_r <= prev_filt_nxt;
    end
  end

  // Divider data registers.
  always_ff @(posedge clk) begin
    dvd_l_r <= dvd_l_nxt;
    dvd_r_r <= dvd_r_nxt;
  end

  // Query datapath: each step ends in a register.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      vl_r  <= mean_l_r * cfg_i.volts_per_lsb;
      vr_r  <= mean_r_r * cfg_i.volts_per_lsb;
      pc1_r <= cfg_i.coeff_input * prev_raw_r;
      pc2_r <= cfg_i.coeff_feedback * prev_filt_r;
    end
    if (state_r == ST_SUM) begin
      diff_r <= diff_nxt;
      acc_r  <= 51'(pc1_r) + 51'(pc2_r);
    end
    if (state_r == ST_GAIN) begin
      prod_r <= diff_r * cfg_i.current_gain;
      y_r    <= y_sat[31:0];
      ysat_r <= y_sat[32];
    end
  end

endmodule

// ===== hw/rtl/dual_adc_average_current_filter_top.sv =====
// ----------------------------------------------------------------------------
// dual_adc_average_current_filter_top: block average differential current
// Averages blocks of left/right converter samples and, on query, returns a
// first order filtered differential current together with both means.
//
//   Channel | Ports                                | Handshake
//   --------+--------------------------------------+--------------------------
//   input   | in_push, in_full, in_data            | push & !full
//   result  | out_pop, out_empty, out_data         | pop & !empty
//   config  | cfg_valid, cfg_ready, cfg_index/data | valid & ready
//
// A sample pair is taken by the back end in its idle state; the pair that closes
// a block goes through the close and one reciprocal multiply for the means.
// A query goes through the accept, the multiply, add and gain steps and the
// hand-off to the output register. A four-word queue separates input
// from the back end. Reset is synchronous; no clearing pass is needed. The
// output register frees the back end as soon as a held result is popped.
// ----------------------------------------------------------------------------
module dual_adc_average_current_filter_top
  import dacf_pkg::*;
#(
  parameter int SAMPLES     = 16,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  dacf_in_t              in_data,
  output logic                  in_full,
  input  logic                  out_pop,
  output dacf_out_t             out_data,
  output logic                  out_empty,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dacf_cfg_t cfg_r, cfg_nxt;
  logic      cmd_valid, cmd_ready;
  dacf_cmd_t cmd;
  logic      res_valid, res_ready;
  dacf_out_t res;
  logic      out_valid_r, out_valid_nxt;
  dacf_out_t out_data_r;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_VOLTS_PER_LSB:  cfg_nxt.volts_per_lsb  = cfg_data;
        REG_OFFSET_LEFT:    cfg_nxt.offset_left    = cfg_data;
        REG_OFFSET_RIGHT:   cfg_nxt.offset_right   = cfg_data;
        REG_CURRENT_GAIN:   cfg_nxt.current_gain   = cfg_data;
        REG_COEFF_INPUT:    cfg_nxt.coeff_input    = cfg_data[17:0];
        REG_COEFF_FEEDBACK: cfg_nxt.coeff_feedback = cfg_data[17:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volts_per_lsb  <= 24'd13521;
      cfg_r.offset_left    <= '0;
      cfg_r.offset_right   <= '0;
      cfg_r.current_gain   <= 24'sd65536;
      cfg_r.coeff_input    <= 18'sd32768;
      cfg_r.coeff_feedback <= 18'sd32768;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept and queue.
  dacf_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // Back: averaging and filter.
  dacf_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Output register: takes a new word when empty or being popped.
  assign res_ready     = ~out_valid_r | out_pop;
  assign out_valid_nxt = res_valid | (out_valid_r & ~out_pop);
  assign out_empty     = ~out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  // A stalled result stays offered by the back end.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid)
    else $error("back end dropped a stalled result");

  // Sample pairs never produce a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready && (cmd.kind == KIND_SAMPLE) |=> !res_valid)
    else $error("sample pair produced a result");

  // Reset leaves no result waiting.
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

endmodule
